[hdl/bfd_pkg.sv]
package bfd_pkg;

    localparam int WORD_BYTES  = 8;
    localparam int DEPTH_WORDS = 128;

    localparam int STORE_BYTES = WORD_BYTES * DEPTH_WORDS;
    localparam int POS_W       = $clog2(STORE_BYTES + 16);
    localparam int IDX_W       = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
    localparam int BOFF_W      = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam int STEP_W      = $clog2(WORD_BYTES + 15);

    localparam int OPC_W   = 2;
    localparam int NBYTE_W = 4;
    localparam int DATA_W  = 64;

    localparam logic [DATA_W-1:0] WORD_MASK = (WORD_BYTES >= 8) ? {DATA_W{1'b1}} :
        ((DATA_W'(1) << (8 * WORD_BYTES)) - DATA_W'(1));

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OPC_W-1:0] {
        OP_OPEN  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLOSE = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [OPC_W-1:0]   kind;
        logic [NBYTE_W-1:0] nbytes;
        logic               do_write;
        logic               do_read;
        logic [IDX_W-1:0]   addr;
        logic [DATA_W-1:0]  data;
    } t_cmd;

    // Byte offset plus step, split into whole words and the new offset.
    function automatic logic [STEP_W-1:0] step_words(input logic [STEP_W-1:0] sum);
        return STEP_W'(sum / WORD_BYTES);
    endfunction

    function automatic logic [BOFF_W-1:0] step_offset(input logic [STEP_W-1:0] sum);
        return BOFF_W'(sum % WORD_BYTES);
    endfunction

    function automatic logic [STEP_W-1:0] words_mod_depth(input logic [STEP_W-1:0] w);
        return STEP_W'(w % DEPTH_WORDS);
    endfunction

endpackage

[hdl/bfd_if.sv]
interface bfd_req_if;
    logic                       valid;
    logic                       ready;
    logic [bfd_pkg::OPC_W-1:0]   opcode;
    logic [bfd_pkg::NBYTE_W-1:0] req_bytes;
    logic [bfd_pkg::DATA_W-1:0]  write_word;

    modport source (output valid, output opcode, output req_bytes, output write_word,
                    input ready);
    modport sink   (input valid, input opcode, input req_bytes, input write_word,
                    output ready);
endinterface

interface bfd_resp_if;
    logic                       valid;
    logic                       ready;
    logic [bfd_pkg::OPC_W-1:0]   resp_kind;
    logic [bfd_pkg::NBYTE_W-1:0] resp_bytes;
    logic [bfd_pkg::DATA_W-1:0]  read_word;

    modport source (output valid, output resp_kind, output resp_bytes, output read_word,
                    input ready);
    modport sink   (input valid, input resp_kind, input resp_bytes, input read_word,
                    output ready);
endinterface

[hdl/block_ram_file_device.sv]
// Channel   Dir  Signals                                   Word
// i_req     in   valid ready opcode req_bytes write_word   one open/write/read/close request
// o_resp    out  valid ready resp_kind resp_bytes read_word one response per request
//
// One request per cycle while the queue is not full; a response becomes valid once its request
// is written into the queue on the accepting edge and then loaded by the back-stage memory access.
// The front tracks position and stored count; a two-entry queue absorbs two more
// requests while the output register stalls, then ready drops until a word drains.
// Reset clears position, count and queue; the memory is not cleared and holds
// undefined words until written.
module block_ram_file_device (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfd_req_if.sink    i_req,
    bfd_resp_if.source o_resp
);
    import bfd_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    bfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    bfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    bfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_resp  (o_resp)
    );

endmodule

[hdl/bfd_front.sv]
module bfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfd_req_if.sink       i_req,
    input  logic          i_full,
    output logic          o_push,
    output bfd_pkg::t_cmd o_cmd
);
    import bfd_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_stored, n_stored;
    logic [IDX_W-1:0]  r_widx, n_widx;
    logic [BOFF_W-1:0] r_boff, n_boff;

    logic              accept;
    logic [STEP_W-1:0] step_sum;
    logic [STEP_W-1:0] step_w;
    logic [IDX_W:0]    idx_sum;
    logic [IDX_W-1:0]  adv_widx;
    logic [BOFF_W-1:0] adv_boff;
    logic [POS_W-1:0]  adv_pos;
    t_opcode           op;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign o_push      = accept;
    assign op          = t_opcode'(i_req.opcode);

    // Advance the word index and in-word offset alongside the byte position.
    always_comb begin
        step_sum = STEP_W'(r_boff) + STEP_W'(i_req.req_bytes);
        step_w   = words_mod_depth(step_words(step_sum));
        adv_boff = step_offset(step_sum);
        idx_sum  = (IDX_W+1)'(r_widx) + (IDX_W+1)'(step_w);
        if (idx_sum >= (IDX_W+1)'(DEPTH_WORDS)) begin
            adv_widx = IDX_W'(idx_sum - (IDX_W+1)'(DEPTH_WORDS));
        end else begin
            adv_widx = IDX_W'(idx_sum);
        end
        adv_pos = r_pos + POS_W'(i_req.req_bytes);
    end

    always_comb begin
        n_pos    = r_pos;
        n_stored = r_stored;
        n_widx   = r_widx;
        n_boff   = r_boff;
        o_cmd.kind     = i_req.opcode;
        o_cmd.nbytes   = '0;
        o_cmd.do_write = 1'b0;
        o_cmd.do_read  = 1'b0;
        o_cmd.addr     = r_widx;
        o_cmd.data     = i_req.write_word & WORD_MASK;
        unique case (op)
            OP_OPEN: begin
                n_pos  = '0;
                n_widx = '0;
                n_boff = '0;
            end
            OP_WRITE: begin
                if (r_stored < POS_W'(STORE_BYTES)) begin
                    o_cmd.do_write = (i_req.req_bytes != '0);
                    o_cmd.nbytes   = i_req.req_bytes;
                    n_pos  = adv_pos;
                    n_widx = adv_widx;
                    n_boff = adv_boff;
                    if (adv_pos > r_stored) begin
                        n_stored = adv_pos;
                    end
                end
            end
            OP_READ: begin
                if (r_pos < r_stored) begin
                    o_cmd.do_read = 1'b1;
                    o_cmd.nbytes  = i_req.req_bytes;
                    n_pos  = adv_pos;
                    n_widx = adv_widx;
                    n_boff = adv_boff;
                end
            end
            OP_CLOSE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_stored <= '0;
            r_widx   <= '0;
            r_boff   <= '0;
        end else if (accept) begin
            r_pos    <= n_pos;
            r_stored <= n_stored;
            r_widx   <= n_widx;
            r_boff   <= n_boff;
        end
    end

endmodule

[hdl/bfd_fifo.sv]
module bfd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bfd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output bfd_pkg::t_cmd o_cmd
);
    import bfd_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_count = r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[hdl/bfd_back.sv]
module bfd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  bfd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    bfd_resp_if.source    o_resp
);
    import bfd_pkg::*;

    logic [DATA_W-1:0]  r_mem [DEPTH_WORDS];
    logic [DATA_W-1:0]  r_rdata;
    logic               r_valid;
    logic [OPC_W-1:0]   r_kind;
    logic [NBYTE_W-1:0] r_nbytes;
    logic               r_is_read;
    logic               load;

    // Take the next word when the output register is free or being drained.
    assign load  = !i_empty && (!r_valid || o_resp.ready);
    assign o_pop = load;

    assign o_resp.valid      = r_valid;
    assign o_resp.resp_kind  = r_kind;
    assign o_resp.resp_bytes = r_nbytes;
    assign o_resp.read_word  = r_is_read ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_cmd.do_write) begin
                r_mem[i_cmd.addr] <= i_cmd.data;
            end
            if (i_cmd.do_read) begin
                r_rdata <= r_mem[i_cmd.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= i_cmd.kind;
            r_nbytes  <= i_cmd.nbytes;
            r_is_read <= i_cmd.do_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_resp.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule
